// File: sv/first_fit_page_extent_allocator_top_macros.svh
`ifndef FIRST_FIT_PAGE_EXTENT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_PAGE_EXTENT_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define FFPA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define FFPA_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/ffpa_pkg.sv
package ffpa_pkg;

  localparam int PAGE_BITS = 20;
  localparam int CNT_BITS = PAGE_BITS + 1;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = CNT_BITS;

  localparam int MAX_FREE_EXTENTS = 64;
  localparam int MAX_ALLOCATIONS = 64;

  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_PAGE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_PAGE = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_INIT  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NO_FIT    = 3'd1,
    STS_RANGE     = 3'd2,
    STS_NOT_ALLOC = 3'd3,
    STS_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_USCAN,
    ST_FSCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    action_t               action;
    logic [CNT_BITS-1:0]   page_count;
    logic [PAGE_BITS-1:0]  page_number;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [PAGE_BITS-1:0]  result_page;
    logic [CNT_BITS-1:0]   result_count;
  } out_item_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0] start;
    logic [CNT_BITS-1:0]  len;
  } free_ent_t;

  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] start;
    logic [CNT_BITS-1:0]  len;
  } used_ent_t;

  typedef struct packed {
    logic shift;
    logic load_head;
  } free_ctl_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic wr;
  } used_ctl_t;

endpackage

// File: sv/first_fit_page_extent_allocator_top.sv
// Allocate and free pass from accept to result through one rotation of the allocation
// cell row, one of the free extent cell row, an optional table write, then the result
// register. A free of a page that starts no allocation skips the free extent row.
// Init, the unused action code and range or zero-count rejects skip both rows and go
// straight to the result register. One item in flight; reset clears state, allocation
// valid bits, the free extent count and region regs.
module first_fit_page_extent_allocator_top #(
  parameter int MAX_FREE_EXTENTS = ffpa_pkg::MAX_FREE_EXTENTS,
  parameter int MAX_ALLOCATIONS  = ffpa_pkg::MAX_ALLOCATIONS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ffpa_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ffpa_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [ffpa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ffpa_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int NF = MAX_FREE_EXTENTS;
  localparam int NA = MAX_ALLOCATIONS;

  ffpa_pkg::free_ent_t free_q [NF];
  ffpa_pkg::used_ent_t used_q [NA];
  ffpa_pkg::free_ctl_t fctl;
  ffpa_pkg::used_ctl_t uctl;
  ffpa_pkg::free_ent_t f_tail;
  ffpa_pkg::free_ent_t f_headval;
  ffpa_pkg::used_ent_t u_wr;
  logic [$clog2(NA)-1:0] u_slot;

  ffpa_ctrl #(
    .NF(NF),
    .NA(NA)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .f_h0      (free_q[0]),
    .f_h1      (free_q[1]),
    .fctl      (fctl),
    .f_tail    (f_tail),
    .f_headval (f_headval),
    .u_head    (used_q[0]),
    .uctl      (uctl),
    .u_slot    (u_slot),
    .u_wr      (u_wr)
  );

  for (genvar k = 0; k < NF; k++) begin : g_free
    if (k == NF - 1) begin : g_tail
      ffpa_free_cell #(.HEAD(k == 0)) u_cell (
        .clk      (clk),
        .ctl      (fctl),
        .nxt      (f_tail),
        .head_val (f_headval),
        .q        (free_q[k])
      );
    end else begin : g_mid
      ffpa_free_cell #(.HEAD(k == 0)) u_cell (
        .clk      (clk),
        .ctl      (fctl),
        .nxt      (free_q[k+1]),
        .head_val (f_headval),
        .q        (free_q[k])
      );
    end
  end

  for (genvar k = 0; k < NA; k++) begin : g_used
    ffpa_used_cell #(
      .NA (NA),
      .IDX(k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (uctl),
      .wr_slot (u_slot),
      .wr_ent  (u_wr),
      .nxt     (used_q[(k + 1) % NA]),
      .q       (used_q[k])
    );
  end

endmodule

// File: sv/ffpa_free_cell.sv
module ffpa_free_cell #(
  parameter bit HEAD = 1'b0
) (
  input  logic                clk,
  input  ffpa_pkg::free_ctl_t ctl,
  input  ffpa_pkg::free_ent_t nxt,
  input  ffpa_pkg::free_ent_t head_val,
  output ffpa_pkg::free_ent_t q
);

  always_ff @(posedge clk) begin
    if (ctl.load_head && HEAD) begin
      q <= head_val;
    end else if (ctl.shift) begin
      q <= nxt;
    end
  end

endmodule

// File: sv/ffpa_used_cell.sv
module ffpa_used_cell #(
  parameter int NA  = ffpa_pkg::MAX_ALLOCATIONS,
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ffpa_pkg::used_ctl_t     ctl,
  input  logic [$clog2(NA)-1:0]   wr_slot,
  input  ffpa_pkg::used_ent_t     wr_ent,
  input  ffpa_pkg::used_ent_t     nxt,
  output ffpa_pkg::used_ent_t     q
);

  localparam int SW = $clog2(NA);
  localparam logic [SW-1:0] MY_SLOT = SW'(IDX);

  logic hit;
  assign hit = ctl.wr && (wr_slot == MY_SLOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (ctl.clear) begin
      q.valid <= 1'b0;
    end else if (hit) begin
      q.valid <= wr_ent.valid;
    end else if (ctl.shift) begin
      q.valid <= nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && wr_ent.valid) begin
      q.start <= wr_ent.start;
      q.len   <= wr_ent.len;
    end else if (ctl.shift) begin
      q.start <= nxt.start;
      q.len   <= nxt.len;
    end
  end

endmodule

// File: sv/ffpa_ctrl.sv
`include "first_fit_page_extent_allocator_top_macros.svh"

module ffpa_ctrl #(
  parameter int NF = ffpa_pkg::MAX_FREE_EXTENTS,
  parameter int NA = ffpa_pkg::MAX_ALLOCATIONS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  ffpa_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ffpa_pkg::out_item_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [ffpa_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ffpa_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  ffpa_pkg::free_ent_t                   f_h0,
  input  ffpa_pkg::free_ent_t                   f_h1,
  output ffpa_pkg::free_ctl_t                   fctl,
  output ffpa_pkg::free_ent_t                   f_tail,
  output ffpa_pkg::free_ent_t                   f_headval,
  input  ffpa_pkg::used_ent_t                   u_head,
  output ffpa_pkg::used_ctl_t                   uctl,
  output logic [$clog2(NA)-1:0]                 u_slot,
  output ffpa_pkg::used_ent_t                   u_wr
);

  localparam int FIW = $clog2(NF);
  localparam int UIW = $clog2(NA);
  localparam int NW = $clog2(NF + 1);
  localparam int PW = ffpa_pkg::PAGE_BITS;
  localparam int CW = ffpa_pkg::CNT_BITS;
  localparam logic [CW-1:0] SPAN = {1'b1, {PW{1'b0}}};

  ffpa_pkg::state_t state, state_next;
  logic [PW-1:0] first_pg;
  logic [CW-1:0] end_pg;
  ffpa_pkg::action_t act, act_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [PW-1:0] pg, pg_next;
  logic [FIW-1:0] fcnt, fcnt_next;
  logic [UIW-1:0] ucnt, ucnt_next;
  logic [NW-1:0] n, n_next;
  logic [UIW-1:0] slot, slot_next;
  logic ufound, ufound_next;
  logic [CW-1:0] ulen, ulen_next;
  logic ffound, ffound_next;
  logic del_on, del_on_next;
  logic ins_on, ins_on_next;
  logic pend_fix, pend_fix_next;
  logic pend_ins, pend_ins_next;
  logic grow, grow_next;
  logic shrink, shrink_next;
  ffpa_pkg::free_ent_t carry, carry_next;
  logic [PW-1:0] gpage, gpage_next;
  ffpa_pkg::status_t sts, sts_next;
  logic out_valid_next;
  ffpa_pkg::out_item_t out_data_next;

  logic [CW-1:0] end_cl;
  logic [NW-1:0] j, j1;
  logic j_lt_n, j1_eq_n, j1_lt_n, tbl_full;
  logic u_hit, p_first, pm1, jp, jn, jn0;
  logic [CW-1:0] pg_end;

  assign end_cl  = (end_pg > SPAN) ? SPAN : end_pg;
  assign j       = NW'(fcnt);
  assign j1      = j + NW'(1);
  assign j_lt_n  = j < n;
  assign j1_eq_n = j1 == n;
  assign j1_lt_n = j1 < n;
  assign tbl_full = n == NW'(NF);
  assign pg_end  = CW'(pg) + ulen;

  assign u_hit = (act == ffpa_pkg::ACT_ALLOC) ? !u_head.valid
                                              : (u_head.valid && u_head.start == pg);

  // insertion point is the first extent at or above the freed page
  assign p_first = !ffound && (fcnt == '0) && ((n == '0) || (f_h0.start >= pg));
  assign pm1 = !ffound && j_lt_n && (f_h0.start < pg) && (j1_eq_n || (f_h1.start >= pg));
  assign jp  = (CW'(f_h0.start) + f_h0.len) == CW'(pg);
  assign jn  = j1_lt_n && (pg_end == CW'(f_h1.start));
  assign jn0 = (n != '0) && (pg_end == CW'(f_h0.start));

  assign f_headval.start = first_pg;
  assign f_headval.len   = end_cl - CW'(first_pg);
  assign u_slot = slot;

  always_comb begin
    state_next     = state;
    act_next       = act;
    cnt_next       = cnt;
    pg_next        = pg;
    fcnt_next      = fcnt;
    ucnt_next      = ucnt;
    n_next         = n;
    slot_next      = slot;
    ufound_next    = ufound;
    ulen_next      = ulen;
    ffound_next    = ffound;
    del_on_next    = del_on;
    ins_on_next    = ins_on;
    pend_fix_next  = pend_fix;
    pend_ins_next  = pend_ins;
    grow_next      = grow;
    shrink_next    = shrink;
    carry_next     = carry;
    gpage_next     = gpage;
    sts_next       = sts;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    in_ready       = 1'b0;
    fctl           = '0;
    uctl           = '0;
    f_tail         = f_h0;
    u_wr           = '0;

    unique case (state)
      ffpa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_next    = in_data.action;
          cnt_next    = in_data.page_count;
          pg_next     = in_data.page_number;
          ucnt_next   = '0;
          ufound_next = 1'b0;
          slot_next   = '0;
          gpage_next  = '0;
          sts_next    = ffpa_pkg::STS_OK;
          state_next  = ffpa_pkg::ST_DONE;
          unique case (in_data.action)
            ffpa_pkg::ACT_ALLOC: begin
              if (in_data.page_count == '0) begin
                sts_next = ffpa_pkg::STS_NO_FIT;
              end else begin
                state_next = ffpa_pkg::ST_USCAN;
              end
            end
            ffpa_pkg::ACT_FREE: begin
              if (in_data.page_number < first_pg || CW'(in_data.page_number) >= end_pg) begin
                sts_next = ffpa_pkg::STS_RANGE;
              end else begin
                state_next = ffpa_pkg::ST_USCAN;
              end
            end
            ffpa_pkg::ACT_INIT: begin
              uctl.clear     = 1'b1;
              fctl.load_head = 1'b1;
              n_next = (end_cl > CW'(first_pg)) ? NW'(1) : '0;
            end
            default: begin
              sts_next = ffpa_pkg::STS_OK;
            end
          endcase
        end
      end

      ffpa_pkg::ST_USCAN: begin
        uctl.shift = 1'b1;
        ucnt_next  = ucnt + UIW'(1);
        if (!ufound && u_hit) begin
          ufound_next = 1'b1;
          slot_next   = ucnt;
          ulen_next   = u_head.len;
        end
        if (ucnt == UIW'(NA - 1)) begin
          if (act == ffpa_pkg::ACT_FREE && !(ufound || u_hit)) begin
            sts_next   = ffpa_pkg::STS_NOT_ALLOC;
            state_next = ffpa_pkg::ST_DONE;
          end else begin
            state_next    = ffpa_pkg::ST_FSCAN;
            fcnt_next     = '0;
            ffound_next   = 1'b0;
            del_on_next   = 1'b0;
            ins_on_next   = 1'b0;
            pend_fix_next = 1'b0;
            pend_ins_next = 1'b0;
            grow_next     = 1'b0;
            shrink_next   = 1'b0;
            sts_next = (act == ffpa_pkg::ACT_ALLOC) ? ffpa_pkg::STS_NO_FIT : ffpa_pkg::STS_OK;
          end
        end
      end

      ffpa_pkg::ST_FSCAN: begin
        // table rotates once through the chain; edits are made on the way back in
        fctl.shift    = 1'b1;
        fcnt_next     = fcnt + FIW'(1);
        pend_fix_next = 1'b0;
        pend_ins_next = 1'b0;
        if (ins_on) begin
          f_tail     = carry;
          carry_next = f_h0;
        end else if (del_on) begin
          f_tail = f_h1;
        end
        if (pend_fix) begin
          f_tail.start = pg;
          f_tail.len   = f_h0.len + ulen;
        end
        if (pend_ins) begin
          f_tail.start = pg;
          f_tail.len   = ulen;
          carry_next   = f_h0;
          ins_on_next  = 1'b1;
        end
        if (act == ffpa_pkg::ACT_ALLOC) begin
          if (!ffound && j_lt_n && f_h0.len >= cnt) begin
            ffound_next = 1'b1;
            if (ufound) begin
              gpage_next = f_h0.start;
              sts_next   = ffpa_pkg::STS_OK;
              if (f_h0.len == cnt) begin
                f_tail      = f_h1;
                del_on_next = 1'b1;
                shrink_next = 1'b1;
              end else begin
                f_tail.start = f_h0.start + PW'(cnt);
                f_tail.len   = f_h0.len - cnt;
              end
            end else begin
              sts_next = ffpa_pkg::STS_FULL;
            end
          end
        end else begin
          if (p_first) begin
            ffound_next = 1'b1;
            if (jn0) begin
              f_tail.start = pg;
              f_tail.len   = f_h0.len + ulen;
            end else if (tbl_full) begin
              sts_next = ffpa_pkg::STS_FULL;
            end else begin
              f_tail.start = pg;
              f_tail.len   = ulen;
              carry_next   = f_h0;
              ins_on_next  = 1'b1;
              grow_next    = 1'b1;
            end
          end else if (pm1) begin
            // this cell precedes the insertion point
            ffound_next = 1'b1;
            if (jp && jn) begin
              f_tail.len  = f_h0.len + ulen + f_h1.len;
              del_on_next = 1'b1;
              shrink_next = 1'b1;
            end else if (jp) begin
              f_tail.len = f_h0.len + ulen;
            end else if (jn) begin
              pend_fix_next = 1'b1;
            end else if (tbl_full) begin
              sts_next = ffpa_pkg::STS_FULL;
            end else begin
              pend_ins_next = 1'b1;
              grow_next     = 1'b1;
            end
          end
        end
        if (fcnt == FIW'(NF - 1)) begin
          n_next = n + NW'(grow_next) - NW'(shrink_next);
          state_next = (sts_next == ffpa_pkg::STS_OK) ? ffpa_pkg::ST_WRITE
                                                       : ffpa_pkg::ST_DONE;
        end
      end

      ffpa_pkg::ST_WRITE: begin
        uctl.wr = 1'b1;
        if (act == ffpa_pkg::ACT_ALLOC) begin
          u_wr.valid = 1'b1;
          u_wr.start = gpage;
          u_wr.len   = cnt;
        end else begin
          u_wr.valid = 1'b0;
          u_wr.start = pg;
          u_wr.len   = ulen;
        end
        state_next = ffpa_pkg::ST_DONE;
      end

      ffpa_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next       = 1'b1;
          out_data_next.status = sts;
          out_data_next.result_page = '0;
          out_data_next.result_count = '0;
          if (sts == ffpa_pkg::STS_OK && act == ffpa_pkg::ACT_ALLOC) begin
            out_data_next.result_page  = gpage;
            out_data_next.result_count = cnt;
          end else if (sts == ffpa_pkg::STS_OK && act == ffpa_pkg::ACT_FREE) begin
            out_data_next.result_count = ulen;
          end
          state_next = ffpa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ffpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffpa_pkg::ST_IDLE;
      n         <= '0;
      out_valid <= 1'b0;
      first_pg  <= '0;
      end_pg    <= '0;
      ufound    <= 1'b0;
      ffound    <= 1'b0;
      del_on    <= 1'b0;
      ins_on    <= 1'b0;
      pend_fix  <= 1'b0;
      pend_ins  <= 1'b0;
      grow      <= 1'b0;
      shrink    <= 1'b0;
    end else begin
      state     <= state_next;
      n         <= n_next;
      out_valid <= out_valid_next;
      ufound    <= ufound_next;
      ffound    <= ffound_next;
      del_on    <= del_on_next;
      ins_on    <= ins_on_next;
      pend_fix  <= pend_fix_next;
      pend_ins  <= pend_ins_next;
      grow      <= grow_next;
      shrink    <= shrink_next;
      if (cfg_we) begin
        unique case (cfg_index)
          ffpa_pkg::REG_FIRST_PAGE: first_pg <= cfg_data[PW-1:0];
          ffpa_pkg::REG_END_PAGE:   end_pg   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    act      <= act_next;
    cnt      <= cnt_next;
    pg       <= pg_next;
    fcnt     <= fcnt_next;
    ucnt     <= ucnt_next;
    slot     <= slot_next;
    ulen     <= ulen_next;
    carry    <= carry_next;
    gpage    <= gpage_next;
    sts      <= sts_next;
    out_data <= out_data_next;
  end

  `FFPA_ASSERT_NXT(a_zero_alloc, in_valid && in_ready && in_data.action == ffpa_pkg::ACT_ALLOC && in_data.page_count == '0, state == ffpa_pkg::ST_DONE, "zero count allocate not answered directly")
  `FFPA_ASSERT_IMP(a_n_bound, 1'b1, n <= NW'(NF), "free extent count over capacity")
  `FFPA_ASSERT_IMP(a_one_edit, state == ffpa_pkg::ST_FSCAN, !(grow && shrink), "insert and delete in one pass")
  `FFPA_ASSERT_NXT(a_write_done, state == ffpa_pkg::ST_WRITE, state == ffpa_pkg::ST_DONE, "table write not followed by result")

endmodule
